// ----- rtl/pwli_pkg.sv -----
// Package for the piecewise linear interpolator: item structs, status and
// state codes, and the sizing constants of the breakpoint store and the sequencer.
// No dependencies.
package pwli_pkg;

   localparam int MAX_POINTS = 64;
   localparam int ADDR_W     = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);

   // Shared adder and iteration lengths
   localparam int ALU_W      = 50;
   localparam int DIV_STEPS  = 49;
   localparam int MUL_STEPS  = 33;
   localparam int STEP_W     = $clog2(DIV_STEPS + 1);

   localparam logic [47:0] SLOPE_POS_MAG = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] SLOPE_NEG_MAG = 48'h8000_0000_0000;
   localparam logic [41:0] TERM_CLAMP    = 42'h100_0000_0000;

   typedef enum logic {
      FUNC_LOAD = 1'b0,
      FUNC_EVAL = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_SATURATED = 2'd1,
      STATUS_TOO_FEW   = 2'd2,
      STATUS_REJECTED  = 2'd3
   } status_type;

   typedef struct packed {
      func_type           func;
      logic [5:0]         point_index;
      logic signed [31:0] x_value;
      logic signed [31:0] y_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] result_value;
      status_type         status;
      logic               extrapolated;
   } rsp_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LOAD_CHK,
      S_SCAN,
      S_FETCH_LO,
      S_FETCH_HI,
      S_DIFF_X,
      S_DIFF_Y,
      S_DIFF_Q,
      S_ABS_DX,
      S_ABS_DY,
      S_ABS_D,
      S_DIV,
      S_SLOPE,
      S_MUL,
      S_ROUND,
      S_SUM,
      S_DONE
   } state_type;

endpackage

// ----- rtl/pwli_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the breakpoint stores of the interpolator; no dependencies.
module pwli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/piecewise_linear_interpolator.sv -----
// Piecewise linear interpolator, top level: breakpoint stores, scan and arithmetic sequencer.
// Depends on pwli_pkg and pwli_ram.
//
// Holds up to 64 signed Q16.16 breakpoints in two RAMs (contents undefined until
// loaded; there is no clearing pass after reset). A load checks its x against the
// slot below and, unless rejected, writes both RAMs. An evaluate transaction runs
// a linear scan over the points in use, reading one x entry per cycle through the RAM read
// port, then a 49-step restoring divider forms the slope and a 33-step shift-add
// multiplier forms the offset, both on one shared 50-bit adder. A vertical segment
// skips the divider; with fewer than two points in use an evaluate goes straight
// to its result. A stalled earlier result holds a finished one in S_DONE.
// One transaction is in progress at a time; a finished result waits in the output
// register while the next transaction is accepted. csr_write_data sets
// points_in_use (reset 0).
module piecewise_linear_interpolator (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pwli_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pwli_pkg::rsp_type rsp_payload,
   input  logic              csr_write_enable,
   input  logic [6:0]        csr_write_data
);

   import pwli_pkg::*;

   // Control state
   state_type             state_ff, state_in;
   logic [6:0]            points_in_use_ff;
   logic [MAX_POINTS-1:0] written_ff, written_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_payload_ff, rsp_payload_in;

   // Transaction and datapath registers
   logic [5:0]         idx_ff, idx_in;
   logic signed [31:0] query_ff, query_in;
   logic signed [31:0] ld_y_ff, ld_y_in;
   logic [CNT_W-1:0]   n_ff, n_in;
   logic [CNT_W-1:0]   scan_cnt_ff, scan_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [CNT_W-1:0]   chk_idx_ff, chk_idx_in;
   logic               found_ff, found_in;
   logic [CNT_W-1:0]   hit_ff, hit_in;
   logic               below_ff, below_in;
   logic               above_ff, above_in;
   logic [CNT_W-1:0]   seg_hi_ff, seg_hi_in;
   logic [31:0]        x1_ff, x1_in;
   logic [31:0]        y1_ff, y1_in;
   logic [31:0]        y2_ff, y2_in;
   logic [32:0]        dx_ff, dx_in;
   logic [32:0]        dy_ff, dy_in;
   logic [32:0]        d_ff, d_in;
   logic               dx_neg_ff, dx_neg_in;
   logic               dy_neg_ff, dy_neg_in;
   logic               d_neg_ff, d_neg_in;
   logic [32:0]        rem_ff, rem_in;
   logic [48:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [47:0]        mcand_ff, mcand_in;
   logic [47:0]        acc_ff, acc_in;
   logic [32:0]        mlo_ff, mlo_in;
   logic               prod_neg_ff, prod_neg_in;
   logic [40:0]        m_ff, m_in;
   rsp_type            res_ff, res_in;

   // Shared adder
   logic [ALU_W-1:0] alu_a, alu_b, alu_sum;
   logic             alu_cin;

   // Memory ports
   logic              ram_wr_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   logic [31:0]       x_rd_data, y_rd_data;

   // Combinational helpers
   logic              req_accept;
   logic [CNT_W-1:0]  n_clamped;
   logic [CNT_W-1:0]  seg_pick;
   logic [33:0]       rem_shift;
   logic              chk_gt;
   logic              slope_neg;
   logic [47:0]       slope_mag;
   logic              term_big;
   logic              rsp_free;

   assign alu_sum = alu_a + alu_b + ALU_W'(alu_cin);

   pwli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (query_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (x_rd_data)
   );

   pwli_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ld_y_ff),
      .rd_addr (ram_rd_addr),
      .rd_data (y_rd_data)
   );

   assign req_accept  = req_valid && (state_ff == S_IDLE);
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   assign n_clamped = (32'(points_in_use_ff) > MAX_POINTS) ? CNT_W'(MAX_POINTS)
                                                          : CNT_W'(points_in_use_ff);
   assign rem_shift = {rem_ff, quo_ff[48]};
   assign chk_gt    = $signed(x_rd_data) > query_ff;
   assign slope_neg = dy_neg_ff ^ dx_neg_ff;
   assign term_big  = (acc_ff[47:24] != '0);

   always_comb begin
      seg_pick = found_ff ? hit_ff : n_ff;
      if (seg_pick == '0) begin
         seg_pick = CNT_W'(1);
      end else if (seg_pick == n_ff) begin
         seg_pick = n_ff - CNT_W'(1);
      end
   end

   always_comb begin
      if (slope_neg) begin
         slope_mag = (quo_ff >= {1'b0, SLOPE_NEG_MAG}) ? SLOPE_NEG_MAG : quo_ff[47:0];
      end else begin
         slope_mag = (quo_ff > {1'b0, SLOPE_POS_MAG}) ? SLOPE_POS_MAG : quo_ff[47:0];
      end
   end

   always_comb begin
      state_in       = state_ff;
      written_in     = written_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      idx_in         = idx_ff;
      query_in       = query_ff;
      ld_y_in        = ld_y_ff;
      n_in           = n_ff;
      scan_cnt_in    = scan_cnt_ff;
      chk_vld_in     = 1'b0;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      hit_in         = hit_ff;
      below_in       = below_ff;
      above_in       = above_ff;
      seg_hi_in      = seg_hi_ff;
      x1_in          = x1_ff;
      y1_in          = y1_ff;
      y2_in          = y2_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      d_in           = d_ff;
      dx_neg_in      = dx_neg_ff;
      dy_neg_in      = dy_neg_ff;
      d_neg_in       = d_neg_ff;
      rem_in         = rem_ff;
      quo_in         = quo_ff;
      step_in        = step_ff;
      mcand_in       = mcand_ff;
      acc_in         = acc_ff;
      mlo_in         = mlo_ff;
      prod_neg_in    = prod_neg_ff;
      m_in           = m_ff;
      res_in         = res_ff;
      alu_a          = '0;
      alu_b          = '0;
      alu_cin        = 1'b0;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = ADDR_W'(idx_ff);
      ram_rd_addr    = ADDR_W'(req_payload.point_index) - ADDR_W'(1);

      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               idx_in      = req_payload.point_index;
               query_in    = req_payload.x_value;
               ld_y_in     = req_payload.y_value;
               n_in        = n_clamped;
               scan_cnt_in = '0;
               found_in    = 1'b0;
               below_in    = 1'b0;
               above_in    = 1'b0;
               if (req_payload.func == FUNC_LOAD) begin
                  state_in = S_LOAD_CHK;
               end else if (n_clamped < CNT_W'(2)) begin
                  res_in   = '{result_value: '0, status: STATUS_TOO_FEW, extrapolated: 1'b0};
                  state_in = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end

         S_LOAD_CHK: begin
            // x of the previous slot is on the read port now
            res_in = '{result_value: '0, status: STATUS_OK, extrapolated: 1'b0};
            if (32'(idx_ff) >= MAX_POINTS) begin
               res_in.status = STATUS_REJECTED;
            end else if ((idx_ff != '0)
                         && written_ff[ADDR_W'(idx_ff) - ADDR_W'(1)]
                         && (query_ff <= $signed(x_rd_data))) begin
               res_in.status = STATUS_REJECTED;
            end else begin
               ram_wr_en                     = 1'b1;
               written_in[ADDR_W'(idx_ff)] = 1'b1;
            end
            state_in = S_DONE;
         end

         S_SCAN: begin
            // Issue one read a cycle, check the entry read the cycle before
            ram_rd_addr = scan_cnt_ff[ADDR_W-1:0];
            if (scan_cnt_ff < n_ff) begin
               chk_vld_in  = 1'b1;
               chk_idx_in  = scan_cnt_ff;
               scan_cnt_in = scan_cnt_ff + CNT_W'(1);
            end
            if (chk_vld_ff) begin
               if (chk_idx_ff == '0) begin
                  below_in = chk_gt;
               end
               if (chk_idx_ff == n_ff - CNT_W'(1)) begin
                  above_in = query_ff > $signed(x_rd_data);
               end
               if (chk_gt && !found_ff) begin
                  found_in = 1'b1;
                  hit_in   = chk_idx_ff;
               end
            end else if (scan_cnt_ff == n_ff) begin
               state_in = S_FETCH_LO;
            end
         end

         S_FETCH_LO: begin
            seg_hi_in   = seg_pick;
            ram_rd_addr = ADDR_W'(seg_pick - CNT_W'(1));
            state_in    = S_FETCH_HI;
         end

         S_FETCH_HI: begin
            ram_rd_addr = seg_hi_ff[ADDR_W-1:0];
            x1_in       = x_rd_data;
            y1_in       = y_rd_data;
            state_in    = S_DIFF_X;
         end

         S_DIFF_X: begin
            alu_a     = {{(ALU_W-32){x_rd_data[31]}}, x_rd_data};
            alu_b     = ~{{(ALU_W-32){x1_ff[31]}}, x1_ff};
            alu_cin   = 1'b1;
            dx_in     = alu_sum[32:0];
            dx_neg_in = alu_sum[32];
            y2_in     = y_rd_data;
            state_in  = S_DIFF_Y;
         end

         S_DIFF_Y: begin
            alu_a     = {{(ALU_W-32){y2_ff[31]}}, y2_ff};
            alu_b     = ~{{(ALU_W-32){y1_ff[31]}}, y1_ff};
            alu_cin   = 1'b1;
            dy_in     = alu_sum[32:0];
            dy_neg_in = alu_sum[32];
            state_in  = S_DIFF_Q;
         end

         S_DIFF_Q: begin
            alu_a    = {{(ALU_W-32){query_ff[31]}}, query_ff};
            alu_b    = ~{{(ALU_W-32){x1_ff[31]}}, x1_ff};
            alu_cin  = 1'b1;
            d_in     = alu_sum[32:0];
            d_neg_in = alu_sum[32];
            state_in = S_ABS_DX;
         end

         S_ABS_DX: begin
            alu_b   = ~{{(ALU_W-33){dx_ff[32]}}, dx_ff};
            alu_cin = 1'b1;
            if (dx_neg_ff) begin
               dx_in = alu_sum[32:0];
            end
            state_in = S_ABS_DY;
         end

         S_ABS_DY: begin
            alu_b   = ~{{(ALU_W-33){dy_ff[32]}}, dy_ff};
            alu_cin = 1'b1;
            if (dy_neg_ff) begin
               dy_in = alu_sum[32:0];
            end
            state_in = S_ABS_D;
         end

         S_ABS_D: begin
            alu_b   = ~{{(ALU_W-33){d_ff[32]}}, d_ff};
            alu_cin = 1'b1;
            if (d_neg_ff) begin
               d_in = alu_sum[32:0];
            end
            rem_in  = '0;
            step_in = STEP_W'(DIV_STEPS);
            if (dx_ff == '0) begin
               // Vertical segment: force saturation toward the sign of dy
               quo_in   = (dy_ff == '0) ? '0 : '1;
               state_in = S_SLOPE;
            end else begin
               quo_in   = {dy_ff, 16'b0};
               state_in = S_DIV;
            end
         end

         S_DIV: begin
            // Restoring division, one quotient bit a cycle
            alu_a   = {{(ALU_W-34){1'b0}}, rem_shift};
            alu_b   = ~{{(ALU_W-33){1'b0}}, dx_ff};
            alu_cin = 1'b1;
            if (!alu_sum[ALU_W-1]) begin
               rem_in = alu_sum[32:0];
            end else begin
               rem_in = rem_shift[32:0];
            end
            quo_in  = {quo_ff[47:0], !alu_sum[ALU_W-1]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_SLOPE;
            end
         end

         S_SLOPE: begin
            mcand_in    = slope_mag;
            acc_in      = '0;
            mlo_in      = d_ff;
            prod_neg_in = slope_neg ^ d_neg_ff;
            step_in     = STEP_W'(MUL_STEPS);
            state_in    = S_MUL;
         end

         S_MUL: begin
            // Shift-add multiply, one multiplier bit a cycle
            alu_a = {2'b0, acc_ff};
            if (mlo_ff[0]) begin
               alu_b = {2'b0, mcand_ff};
            end
            acc_in  = alu_sum[48:1];
            mlo_in  = {alu_sum[0], mlo_ff[32:1]};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               state_in = S_ROUND;
            end
         end

         S_ROUND: begin
            // Floor of a negative product: bump the magnitude if bits dropped
            alu_a   = {9'b0, acc_ff[23:0], mlo_ff[32:16]};
            alu_cin = prod_neg_ff && (mlo_ff[15:0] != '0);
            if (term_big || (alu_sum[41:0] > TERM_CLAMP)) begin
               m_in = TERM_CLAMP[40:0];
            end else begin
               m_in = alu_sum[40:0];
            end
            state_in = S_SUM;
         end

         S_SUM: begin
            alu_a   = {{(ALU_W-32){y1_ff[31]}}, y1_ff};
            alu_b   = prod_neg_ff ? ~{{(ALU_W-41){1'b0}}, m_ff} : {{(ALU_W-41){1'b0}}, m_ff};
            alu_cin = prod_neg_ff;
            res_in.extrapolated = below_ff || above_ff;
            if (!alu_sum[ALU_W-1] && (alu_sum[ALU_W-2:31] != '0)) begin
               res_in.result_value = 32'sh7FFF_FFFF;
               res_in.status       = STATUS_SATURATED;
            end else if (alu_sum[ALU_W-1] && (alu_sum[ALU_W-2:31] != '1)) begin
               res_in.result_value = 32'sh8000_0000;
               res_in.status       = STATUS_SATURATED;
            end else begin
               res_in.result_value = alu_sum[31:0];
               res_in.status       = STATUS_OK;
            end
            state_in = S_DONE;
         end

         S_DONE: begin
            // Hold until the output register is free
            if (rsp_free) begin
               rsp_valid_in   = 1'b1;
               rsp_payload_in = res_ff;
               state_in       = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         points_in_use_ff <= '0;
         written_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         chk_vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         written_ff   <= written_in;
         rsp_valid_ff <= rsp_valid_in;
         chk_vld_ff   <= chk_vld_in;
         if (csr_write_enable) begin
            points_in_use_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
      idx_ff         <= idx_in;
      query_ff       <= query_in;
      ld_y_ff        <= ld_y_in;
      n_ff           <= n_in;
      scan_cnt_ff    <= scan_cnt_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      hit_ff         <= hit_in;
      below_ff       <= below_in;
      above_ff       <= above_in;
      seg_hi_ff      <= seg_hi_in;
      x1_ff          <= x1_in;
      y1_ff          <= y1_in;
      y2_ff          <= y2_in;
      dx_ff          <= dx_in;
      dy_ff          <= dy_in;
      d_ff           <= d_in;
      dx_neg_ff      <= dx_neg_in;
      dy_neg_ff      <= dy_neg_in;
      d_neg_ff       <= d_neg_in;
      rem_ff         <= rem_in;
      quo_ff         <= quo_in;
      step_ff        <= step_in;
      mcand_ff       <= mcand_in;
      acc_ff         <= acc_in;
      mlo_ff         <= mlo_in;
      prod_neg_ff    <= prod_neg_in;
      m_ff           <= m_in;
      res_ff         <= res_in;
   end

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the piecewise linear interpolator: directed and random
// load/evaluate transactions checked against an in-bench table predictor.
// Depends on pwli_pkg and the piecewise_linear_interpolator RTL.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pwli_pkg::*;

   localparam int     RANDOM_REQUESTS = 1800;
   localparam int     QUIET_TAIL      = 250;
   localparam int     DRAIN_CYCLES    = 200;
   localparam int     TIMEOUT_NS      = 25_000_000;

   localparam longint Q_MAX        = 64'sh7FFF_FFFF;
   localparam longint Q_MIN        = -64'sh8000_0000;
   localparam longint SLOPE_TOP    = 64'sh7FFF_FFFF_FFFF;
   localparam longint SLOPE_BOTTOM = -64'sh8000_0000_0000;
   localparam logic [63:0] TERM_LIMIT = 64'd1 << 40;

   localparam logic signed [31:0] FIELD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] FIELD_MAX = 32'sh7FFF_FFFF;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_payload;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_payload;
   logic    csr_write_enable;
   logic [6:0] csr_write_data;

   // Predictor copy of the breakpoint store and register
   logic signed [31:0] table_x [MAX_POINTS];
   logic signed [31:0] table_y [MAX_POINTS];
   bit                 table_loaded [MAX_POINTS];
   logic [6:0]         active_points = '0;

   rsp_type predicted_rsps [$];
   int      accepted_requests = 0;
   int      mismatch_count    = 0;
   bit      idle_enable       = 1'b1;

   piecewise_linear_interpolator uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_top: done, errors");
      $finish;
   end

   function automatic logic signed [31:0] to_q(input longint v);
      if (v > Q_MAX)
         return FIELD_MAX;
      else if (v < Q_MIN)
         return FIELD_MIN;
      return v[31:0];
   endfunction

   function automatic logic [63:0] abs_value(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Expected response of one accepted transaction; loads update the table copy
   function automatic rsp_type interpolator_response(input req_type item);
      rsp_type     rsp;
      int          used, seg, k;
      longint      x_lo, y_lo, dx, dy, dq, slope, total;
      logic [63:0] quot, term_mag;
      logic [95:0] mag_a, mag_b, product;
      bit          negative;
      rsp = '0;
      rsp.status = STATUS_OK;
      if (item.func == FUNC_LOAD) begin
         k = int'(item.point_index);
         if (k >= MAX_POINTS)
            rsp.status = STATUS_REJECTED;
         else if (k > 0 && table_loaded[k-1] && item.x_value <= table_x[k-1])
            rsp.status = STATUS_REJECTED;
         else begin
            table_x[k]      = item.x_value;
            table_y[k]      = item.y_value;
            table_loaded[k] = 1'b1;
         end
         return rsp;
      end
      used = (active_points > MAX_POINTS) ? MAX_POINTS : int'(active_points);
      if (used < 2) begin
         rsp.status = STATUS_TOO_FEW;
         return rsp;
      end
      seg = 0;
      while (seg < used && table_x[seg] <= item.x_value)
         seg++;
      rsp.extrapolated = (item.x_value < table_x[0]) || (item.x_value > table_x[used-1]);
      if (seg == 0)
         seg = 1;
      if (seg == used)
         seg = used - 1;
      x_lo = table_x[seg-1];
      y_lo = table_y[seg-1];
      dx   = longint'(table_x[seg]) - x_lo;
      dy   = longint'(table_y[seg]) - y_lo;
      dq   = longint'(item.x_value) - x_lo;
      negative = (dy < 0) != (dx < 0);
      if (dx == 0)
         slope = (dy == 0) ? 0 : (dy > 0) ? SLOPE_TOP : SLOPE_BOTTOM;
      else begin
         quot = (abs_value(dy) << 16) / abs_value(dx);
         if (negative)
            slope = (quot >= 64'h8000_0000_0000) ? SLOPE_BOTTOM : -longint'(quot);
         else
            slope = (quot > SLOPE_TOP) ? SLOPE_TOP : longint'(quot);
      end
      // floor of slope * dq / 2^16, magnitude held at the term limit
      negative = (slope < 0) != (dq < 0);
      mag_a    = 96'(abs_value(slope));
      mag_b    = 96'(abs_value(dq));
      product  = mag_a * mag_b;
      term_mag = (product[95:80] != 0) ? TERM_LIMIT : product[79:16];
      if (negative && product[15:0] != 0)
         term_mag++;
      if (term_mag > TERM_LIMIT)
         term_mag = TERM_LIMIT;
      total = y_lo + (negative ? -longint'(term_mag) : longint'(term_mag));
      rsp.result_value = to_q(total);
      if (total > Q_MAX || total < Q_MIN)
         rsp.status = STATUS_SATURATED;
      return rsp;
   endfunction

   task automatic send_request(input req_type item);
      if (idle_enable && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      predicted_rsps.push_back(interpolator_response(item));
      accepted_requests++;
   endtask

   task automatic load_point(input int slot, input logic signed [31:0] x,
                             input logic signed [31:0] y);
      req_type item;
      item.func        = FUNC_LOAD;
      item.point_index = slot[5:0];
      item.x_value     = x;
      item.y_value     = y;
      send_request(item);
   endtask

   task automatic evaluate_at(input logic signed [31:0] q);
      req_type item;
      item.func        = FUNC_EVAL;
      item.point_index = 6'($urandom_range(0, 63));
      item.x_value     = q;
      item.y_value     = $urandom;
      send_request(item);
   endtask

   // Hold the sender until every outstanding transaction has returned
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (predicted_rsps.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_points_in_use(input int count);
      wait_for_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= count[6:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_points = count[6:0];
   endtask

   task automatic test_too_few();
      set_points_in_use(0);
      evaluate_at(32'sh0001_0000);
      set_points_in_use(1);
      load_point(0, FIELD_MIN, FIELD_MAX);
      evaluate_at(FIELD_MIN);
   endtask

   task automatic test_load_rules();
      load_point(1, FIELD_MAX, FIELD_MIN);
      // equal x to the slot below: rejected
      load_point(2, FIELD_MAX, 32'sh0000_0000);
      load_point(1, FIELD_MIN, 32'sh0001_0000);
      // slot below never written: no ordering check
      load_point(63, 32'sh0000_0000, 32'sh0000_0000);
   endtask

   task automatic test_full_range_segment();
      set_points_in_use(2);
      evaluate_at(FIELD_MAX);
      evaluate_at(FIELD_MIN);
      evaluate_at(32'sh0000_0000);
   endtask

   task automatic test_saturation();
      load_point(0, 32'sh0000_0000, FIELD_MIN);
      load_point(1, 32'sh0000_0001, FIELD_MAX);
      evaluate_at(32'sh0001_0000);
      evaluate_at(FIELD_MIN);
      evaluate_at(32'sh0000_0001);
      evaluate_at(32'sh0000_0000);
   endtask

   task automatic test_zero_width();
      // slot 0 has no ordering check, so it can match the x of slot 1
      load_point(0, 32'sh0000_0001, 32'sh0005_0000);
      evaluate_at(32'sh0000_0001);
      evaluate_at(32'sh0000_0002);
      evaluate_at(32'sh0000_0000);
      load_point(0, 32'sh0000_0001, FIELD_MAX);
      evaluate_at(32'sh0064_0000);
   endtask

   // Fill slots 0..len-1 with strictly rising x and random y
   task automatic load_ascending_table(input int len);
      longint step_max, room, x, y, delta;
      int     k, y_mode;
      case ($urandom_range(0, 3))
         0:       step_max = 15;
         1:       step_max = 65535;
         2:       step_max = 64'd1 << 22;
         default: step_max = 64'hFFFF_FFFF / len - 1;
      endcase
      room   = 64'hFFFF_FFFF - longint'(len) * (step_max + 1);
      delta  = $urandom_range(0, room[31:0]);
      x      = Q_MIN + delta;
      y      = $signed($urandom);
      y_mode = $urandom_range(0, 2);
      for (k = 0; k < len; k++) begin
         if (k > 0) begin
            delta = $urandom_range(0, step_max[31:0]);
            x     = x + 1 + delta;
         end
         case (y_mode)
            0: y = $signed($urandom);
            1: begin
               delta = $urandom_range(0, 1 << 21);
               y     = to_q(y + delta - (1 << 20));
            end
            default: begin
               delta = $urandom_range(0, 1 << 25);
               y     = delta - (1 << 24);
            end
         endcase
         load_point(k, x[31:0], y[31:0]);
      end
   endtask

   function automatic logic signed [31:0] pick_query(input int len);
      longint lo, span, offset;
      int     k;
      offset = $urandom_range(0, 1 << 20);
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: return table_x[$urandom_range(0, len - 1)];
         2: return to_q(longint'(table_x[0]) - 1 - offset);
         3: return to_q(longint'(table_x[len-1]) + 1 + offset);
         default: begin
            k    = $urandom_range(0, len - 2);
            lo   = table_x[k];
            span = longint'(table_x[k+1]) - lo;
            if (span <= 0)
               return lo[31:0];
            offset = $urandom_range(0, span[31:0]);
            return to_q(lo + offset);
         end
      endcase
   endfunction

   task automatic noise_load();
      int     k;
      longint offset;
      k      = $urandom_range(0, 63);
      offset = $urandom_range(0, 3);
      if (k > 0 && $urandom_range(0, 1) == 1)
         load_point(k, to_q(longint'(table_x[k-1]) - offset), $urandom);
      else
         load_point(k, $urandom, $urandom);
   endtask

   task automatic test_random_tables();
      int start, phase, pick, count, len;
      start = accepted_requests;
      phase = 0;
      while (accepted_requests - start < RANDOM_REQUESTS) begin
         if (accepted_requests - start > RANDOM_REQUESTS - QUIET_TAIL)
            idle_enable = 1'b0;
         pick = $urandom_range(0, 19);
         // first phase loads every slot, so later scans never read an empty one
         if (phase == 0)
            count = 127;
         else if (pick == 0)
            count = $urandom_range(0, 1);
         else if (pick == 1)
            count = $urandom_range(65, 127);
         else if (pick < 5)
            count = MAX_POINTS;
         else if (pick < 9)
            count = $urandom_range(17, 63);
         else
            count = $urandom_range(2, 16);
         len = (count > MAX_POINTS) ? MAX_POINTS : (count < 2) ? 2 : count;
         set_points_in_use(count);
         load_ascending_table(len);
         repeat ($urandom_range(15, 40)) begin
            if ($urandom_range(0, 19) < 3)
               noise_load();
            else
               evaluate_at(pick_query(len));
            if (idle_enable && $urandom_range(0, 59) == 0)
               wait_for_results();
         end
         phase++;
      end
   endtask

   // Result side back-pressure
   initial begin
      rsp_stall = 1'b0;
      forever begin
         if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(100, 400)) @(posedge clock);
         else
            repeat ($urandom_range(1, 24)) @(posedge clock);
         if (idle_enable && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 13)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (predicted_rsps.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with no transaction pending: %h", $time, rsp_payload);
         end else begin
            want = predicted_rsps.pop_front();
            if (rsp_payload.result_value !== want.result_value ||
                rsp_payload.status !== want.status ||
                rsp_payload.extrapolated !== want.extrapolated) begin
               mismatch_count++;
               $display("%0t: expected %h/%0d/%0d, got %h/%0d/%0d",
                        $time, want.result_value, want.status, want.extrapolated,
                        rsp_payload.result_value, rsp_payload.status,
                        rsp_payload.extrapolated);
            end
         end
      end
   end

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_payload      = '0;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_too_few();
      test_load_rules();
      test_full_range_segment();
      test_saturation();
      test_zero_width();
      test_random_tables();
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && predicted_rsps.size() == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pwli_pkg.sv
rtl/pwli_ram.sv
rtl/piecewise_linear_interpolator.sv
tb/sv/tb_top.sv
